/* src/stepper_move_backlash_pulser_defines.svh */
// Assertion macros for the stepper move pulser.
`ifndef STEPPER_MOVE_BACKLASH_PULSER_DEFINES_SVH
`define STEPPER_MOVE_BACKLASH_PULSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SMBP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smbp assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SMBP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smbp assertion failed");

`endif

/* src/smbp_pkg.sv */
// Shared types, codes and constants for the stepper move pulser.
package smbp_pkg;

	localparam int unsigned CFG_W      = 16;
	localparam int unsigned REG_IDX_W  = 2;
	localparam int unsigned STEPS_W    = 23;
	localparam int unsigned PHASE_W    = 17;
	localparam int unsigned POS_W      = 32;
	localparam int unsigned DIST_W     = 16;
	localparam int unsigned PROD_W     = CFG_W + DIST_W;

	// Item kinds
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_MOVE   = 2'd1;
	localparam logic [1:0] KIND_TOGGLE = 2'd2;

	// Toggle targets
	localparam logic [1:0] PIN_DIR     = 2'd0;
	localparam logic [1:0] PIN_STEP    = 2'd1;
	localparam logic [1:0] PIN_ENABLE  = 2'd2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_MICROSTEPS_PER_MM = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BACKLASH_INWARD   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BACKLASH_OUTWARD  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_HALF_PERIOD       = 2'd3;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_MICROSTEPS_PER_MM = 16'd470;
	localparam logic [CFG_W-1:0] RST_BACKLASH_INWARD   = 16'd200;
	localparam logic [CFG_W-1:0] RST_BACKLASH_OUTWARD  = 16'd240;
	localparam logic [CFG_W-1:0] RST_HALF_PERIOD       = 16'd156;

	// Divide by microns per mm as multiply by rounded-up reciprocal, then shift
	localparam longint unsigned MICRONS_PER_MM = 1000;
	localparam int unsigned     DIV_SHIFT      = 38;
	localparam int unsigned     MAGIC_W        = 29;
	localparam int unsigned     QPROD_W        = PROD_W + MAGIC_W;
	localparam logic [MAGIC_W-1:0] DIV_MAGIC   =
		MAGIC_W'(((64'd1 << DIV_SHIFT) + MICRONS_PER_MM - 1) / MICRONS_PER_MM);

	typedef struct packed {
		logic [CFG_W-1:0] microsteps_per_mm;
		logic [CFG_W-1:0] backlash_to_inward;
		logic [CFG_W-1:0] backlash_to_outward;
		logic [CFG_W-1:0] half_period_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               direction;
		logic [1:0]         pin_select;
		logic [STEPS_W-1:0] quotient;
	} item_t;

endpackage

/* src/smbp_calc.sv */
// Move-count arithmetic pipeline: input register, rate product, divide by 1000.
module smbp_calc (
	input  logic                            clk,
	input  logic                            arst_n,
	input  smbp_pkg::cfg_t                  cfg,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      kind,
	input  logic                            direction,
	input  logic [smbp_pkg::DIST_W-1:0]     distance_microns,
	input  logic [1:0]                      pin_select,
	output logic                            item_valid,
	output smbp_pkg::item_t                 item,
	input  logic                            item_ready
);

	logic                          v_s1, v_s2, v_s3;
	logic                          en_s1, en_s2, en_s3;
	logic [1:0]                    kind_s1, kind_s2;
	logic                          dir_s1, dir_s2;
	logic [1:0]                    pin_s1, pin_s2;
	logic [smbp_pkg::DIST_W-1:0]   dist_s1;
	logic [smbp_pkg::PROD_W-1:0]   prod_s2;
	logic [smbp_pkg::QPROD_W-1:0]  qprod;
	smbp_pkg::item_t               item_s3;

	// Advance a stage when it is empty or its successor takes its content
	assign en_s3    = !v_s3 || item_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1 <= kind;
			dir_s1  <= direction;
			pin_s1  <= pin_select;
			dist_s1 <= distance_microns;
		end
	end

	// Form microsteps times microns
	always_ff @(posedge clk) begin
		if (en_s2) begin
			kind_s2 <= kind_s1;
			dir_s2  <= dir_s1;
			pin_s2  <= pin_s1;
			prod_s2 <= smbp_pkg::PROD_W'(cfg.microsteps_per_mm) *
				smbp_pkg::PROD_W'(dist_s1);
		end
	end

	// Divide by microns per mm through the reciprocal
	assign qprod = smbp_pkg::QPROD_W'(prod_s2) * smbp_pkg::QPROD_W'(smbp_pkg::DIV_MAGIC);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			item_s3.kind       <= kind_s2;
			item_s3.direction  <= dir_s2;
			item_s3.pin_select <= pin_s2;
			item_s3.quotient   <= qprod[smbp_pkg::DIV_SHIFT +: smbp_pkg::STEPS_W];
		end
	end

	assign item_valid = v_s3;
	assign item       = item_s3;

endmodule

/* src/smbp_engine.sv */
// Step engine: pin and position state, step timing and the result register.
module smbp_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  smbp_pkg::cfg_t               cfg,
	input  logic                         item_valid,
	input  smbp_pkg::item_t              item,
	output logic                         item_ready,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         step_level,
	output logic                         dir_level,
	output logic                         enable_level,
	output logic                         busy_res,
	output logic                         move_done,
	output logic                         rejected,
	output logic signed [smbp_pkg::POS_W-1:0] position
);

	logic [smbp_pkg::STEPS_W-1:0] steps_q, steps_n, count;
	logic [smbp_pkg::PHASE_W-1:0] phase_q, phase_n, phase_inc;
	logic [smbp_pkg::POS_W-1:0]   pos_q, pos_n;
	logic                         last_dir_q, last_dir_n;
	logic                         step_q, step_n;
	logic                         dir_q, dir_n;
	logic                         en_q, en_n;
	logic                         done, rej, busy, adv;
	logic [smbp_pkg::CFG_W-1:0]   half, backlash;
	logic                         out_valid_q;

	assign item_ready = !out_valid_q || !out_stall;
	assign adv        = item_valid && item_ready;

	// Work out the next state for the item at the head
	always_comb begin
		steps_n    = steps_q;
		phase_n    = phase_q;
		pos_n      = pos_q;
		last_dir_n = last_dir_q;
		step_n     = step_q;
		dir_n      = dir_q;
		en_n       = en_q;
		done       = 1'b0;
		rej        = 1'b0;
		busy       = steps_q != '0;
		half       = (cfg.half_period_ticks == '0) ? smbp_pkg::CFG_W'(1) : cfg.half_period_ticks;
		phase_inc  = phase_q + smbp_pkg::PHASE_W'(1);
		backlash   = item.direction ? cfg.backlash_to_outward : cfg.backlash_to_inward;
		count      = item.quotient +
			((item.direction != last_dir_q) ? smbp_pkg::STEPS_W'(backlash) : '0);
		case (item.kind)
			smbp_pkg::KIND_TICK: begin
				if (busy) begin
					if (phase_inc >= smbp_pkg::PHASE_W'(half)) begin
						phase_n = '0;
						if (step_q) begin
							step_n = 1'b0;
						end else begin
							pos_n   = last_dir_q ? pos_q + smbp_pkg::POS_W'(1) :
								pos_q - smbp_pkg::POS_W'(1);
							steps_n = steps_q - smbp_pkg::STEPS_W'(1);
							if (steps_q == smbp_pkg::STEPS_W'(1)) begin
								en_n = 1'b1;
								done = 1'b1;
							end else begin
								step_n = 1'b1;
							end
						end
					end else begin
						phase_n = phase_inc;
					end
				end
			end
			smbp_pkg::KIND_MOVE: begin
				if (busy) begin
					rej = 1'b1;
				end else begin
					last_dir_n = item.direction;
					dir_n      = item.direction;
					steps_n    = count;
					phase_n    = '0;
					if (count == '0) begin
						en_n = 1'b1;
						done = 1'b1;
					end else begin
						en_n   = 1'b0;
						step_n = 1'b1;
					end
				end
			end
			smbp_pkg::KIND_TOGGLE: begin
				if (busy) begin
					rej = 1'b1;
				end else begin
					case (item.pin_select)
						smbp_pkg::PIN_DIR:    dir_n  = !dir_q;
						smbp_pkg::PIN_STEP:   step_n = !step_q;
						smbp_pkg::PIN_ENABLE: en_n   = !en_q;
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// Hold state; advance it when the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q    <= '0;
			phase_q    <= '0;
			pos_q      <= '0;
			last_dir_q <= 1'b1;
			step_q     <= 1'b0;
			dir_q      <= 1'b0;
			en_q       <= 1'b1;
		end else if (adv) begin
			steps_q    <= steps_n;
			phase_q    <= phase_n;
			pos_q      <= pos_n;
			last_dir_q <= last_dir_n;
			step_q     <= step_n;
			dir_q      <= dir_n;
			en_q       <= en_n;
		end
	end

	// Result valid: drop when taken, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_ready) begin
			out_valid_q <= item_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			step_level   <= step_n;
			dir_level    <= dir_n;
			enable_level <= en_n;
			busy_res     <= steps_n != '0;
			move_done    <= done;
			rejected     <= rej;
			position     <= pos_n;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* src/stepper_move_backlash_pulser.sv */
// Top level of the stepper move pulser with backlash compensation.
// Input channel (in_valid / in_stall) takes one request per item: a time tick,
// a move (direction, distance in microns) or a pin toggle. Output channel
// (out_valid / out_stall) returns exactly one result per request: pin levels,
// busy, move done, rejected and the signed microstep position.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 rate,
// 1 inward backlash, 2 outward backlash, 3 half period); write only while idle.
// A request passes the input register, the register of the 16x16 rate multiply,
// the register after the reciprocal multiply that divides by 1000 and the step
// engine's result register. Throughput: one request per cycle while not stalled.
// Step state is updated only in the last stage, so requests in flight
// see each other in order.
// When the receiver stalls, the result register holds and the three stages
// in front keep filling; in_stall rises once all of them are full.
// Reset: registers return to their defaults, driver disabled (enable high),
// position zero, last direction outward, no result pending.
`include "stepper_move_backlash_pulser_defines.svh"

module stepper_move_backlash_pulser (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [smbp_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [smbp_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           kind,
	input  logic                                 direction,
	input  logic [smbp_pkg::DIST_W-1:0]          distance_microns,
	input  logic [1:0]                           pin_select,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 step_level,
	output logic                                 dir_level,
	output logic                                 enable_level,
	output logic                                 busy_res,
	output logic                                 move_done,
	output logic                                 rejected,
	output logic signed [smbp_pkg::POS_W-1:0]    position
);

	smbp_pkg::cfg_t  cfg_q;
	smbp_pkg::item_t item;
	logic            item_valid, item_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.microsteps_per_mm   <= smbp_pkg::RST_MICROSTEPS_PER_MM;
			cfg_q.backlash_to_inward  <= smbp_pkg::RST_BACKLASH_INWARD;
			cfg_q.backlash_to_outward <= smbp_pkg::RST_BACKLASH_OUTWARD;
			cfg_q.half_period_ticks   <= smbp_pkg::RST_HALF_PERIOD;
		end else if (cfg_we) begin
			case (cfg_index)
				smbp_pkg::REG_MICROSTEPS_PER_MM: cfg_q.microsteps_per_mm   <= cfg_data;
				smbp_pkg::REG_BACKLASH_INWARD:   cfg_q.backlash_to_inward  <= cfg_data;
				smbp_pkg::REG_BACKLASH_OUTWARD:  cfg_q.backlash_to_outward <= cfg_data;
				smbp_pkg::REG_HALF_PERIOD:       cfg_q.half_period_ticks   <= cfg_data;
				default: ;
			endcase
		end
	end

	smbp_calc u_calc (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.direction        (direction),
		.distance_microns (distance_microns),
		.pin_select       (pin_select),
		.item_valid       (item_valid),
		.item             (item),
		.item_ready       (item_ready)
	);

	smbp_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_valid   (item_valid),
		.item         (item),
		.item_ready   (item_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.step_level   (step_level),
		.dir_level    (dir_level),
		.enable_level (enable_level),
		.busy_res     (busy_res),
		.move_done    (move_done),
		.rejected     (rejected),
		.position     (position)
	);

	// A finished move leaves the driver disabled and nothing pending
	`SMBP_ASSERT_NOW(a_done_idle, out_valid && move_done, !busy_res && enable_level)
	// The driver stays enabled while a move runs
	`SMBP_ASSERT_NOW(a_busy_enabled, out_valid && busy_res, !enable_level)
	// A rejected request never finishes a move
	`SMBP_ASSERT_NOW(a_rej_not_done, out_valid && rejected, !move_done)
	// Input backs up only behind a stalled, full result register
	`SMBP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

endmodule

/* tb/smbp_checker.sv */
`timescale 1ns / 1ps
// Checker for the stepper move pulser: models the motor, predicts each result and compares.
module smbp_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [smbp_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [smbp_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic                              direction,
	input  logic [smbp_pkg::DIST_W-1:0]       distance_microns,
	input  logic [1:0]                        pin_select,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              step_level,
	input  logic                              dir_level,
	input  logic                              enable_level,
	input  logic                              busy_res,
	input  logic                              move_done,
	input  logic                              rejected,
	input  logic signed [smbp_pkg::POS_W-1:0] position,
	output int                                fail_count,
	output int                                pending_count,
	output int                                result_count,
	output int                                done_count,
	output int                                reject_count,
	output logic                              motor_busy
);

	typedef struct packed {
		logic                              step_lv;
		logic                              dir_lv;
		logic                              enable_lv;
		logic                              busy;
		logic                              done;
		logic                              rej;
		logic signed [smbp_pkg::POS_W-1:0] pos;
	} pins_t;

	pins_t expected_pins_q[$];

	// Model copy of the registers and the motor state
	smbp_pkg::cfg_t                    cfg;
	logic [smbp_pkg::STEPS_W-1:0]      steps_left;
	logic [smbp_pkg::PHASE_W-1:0]      phase_ticks;
	logic                              last_dir;
	logic                              step_pin;
	logic                              dir_pin;
	logic                              drv_off_pin;
	logic signed [smbp_pkg::POS_W-1:0] microstep_pos;

	task automatic report_mismatch(input string what);
		if (fail_count < 50)
			$display("%0t ns: result %0d: %s", $time, result_count, what);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [smbp_pkg::POS_W-1:0] got,
			input logic [smbp_pkg::POS_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	// Apply one request to the motor model and return the pin levels it leaves
	task automatic advance_motor(input logic [1:0] k, input logic d,
			input logic [smbp_pkg::DIST_W-1:0] microns, input logic [1:0] pin,
			output pins_t res);
		logic                         busy;
		logic [smbp_pkg::PHASE_W-1:0] half;
		logic [smbp_pkg::PROD_W-1:0]  count;
		busy = (steps_left != '0);
		half = (cfg.half_period_ticks == '0) ? smbp_pkg::PHASE_W'(1) :
			smbp_pkg::PHASE_W'(cfg.half_period_ticks);
		res = '0;
		case (k)
		smbp_pkg::KIND_TICK: begin
			if (busy) begin
				phase_ticks = phase_ticks + 1'b1;
				if (phase_ticks >= half) begin
					phase_ticks = '0;
					if (step_pin) begin
						step_pin = 1'b0;
					end else begin
						// end of the low half: one microstep taken
						microstep_pos = last_dir ? microstep_pos + 1 : microstep_pos - 1;
						steps_left = steps_left - 1'b1;
						if (steps_left == '0) begin
							drv_off_pin = 1'b1;
							res.done = 1'b1;
						end else begin
							step_pin = 1'b1;
						end
					end
				end
			end
		end
		smbp_pkg::KIND_MOVE: begin
			if (busy) begin
				res.rej = 1'b1;
			end else begin
				count = (smbp_pkg::PROD_W'(cfg.microsteps_per_mm) *
					smbp_pkg::PROD_W'(microns)) /
					smbp_pkg::PROD_W'(smbp_pkg::MICRONS_PER_MM);
				// reversal picks up the backlash of the new direction
				if (d != last_dir)
					count = count + (d ? cfg.backlash_to_outward : cfg.backlash_to_inward);
				last_dir = d;
				dir_pin = d;
				drv_off_pin = 1'b0;
				steps_left = smbp_pkg::STEPS_W'(count);
				phase_ticks = '0;
				if (steps_left == '0) begin
					drv_off_pin = 1'b1;
					res.done = 1'b1;
				end else begin
					step_pin = 1'b1;
				end
			end
		end
		smbp_pkg::KIND_TOGGLE: begin
			if (busy) begin
				res.rej = 1'b1;
			end else begin
				case (pin)
				smbp_pkg::PIN_DIR:    dir_pin = !dir_pin;
				smbp_pkg::PIN_STEP:   step_pin = !step_pin;
				smbp_pkg::PIN_ENABLE: drv_off_pin = !drv_off_pin;
				default:              ;
				endcase
			end
		end
		default: ;
		endcase
		res.step_lv = step_pin;
		res.dir_lv = dir_pin;
		res.enable_lv = drv_off_pin;
		res.busy = (steps_left != '0);
		res.pos = microstep_pos;
	endtask

	// Compare one accepted result with the oldest prediction
	task automatic compare_result();
		pins_t want;
		if (expected_pins_q.size() == 0) begin
			report_mismatch("result with no request outstanding");
		end else begin
			want = expected_pins_q.pop_front();
			check_field("step_level", smbp_pkg::POS_W'(step_level),
				smbp_pkg::POS_W'(want.step_lv));
			check_field("dir_level", smbp_pkg::POS_W'(dir_level),
				smbp_pkg::POS_W'(want.dir_lv));
			check_field("enable_level", smbp_pkg::POS_W'(enable_level),
				smbp_pkg::POS_W'(want.enable_lv));
			check_field("busy_res", smbp_pkg::POS_W'(busy_res),
				smbp_pkg::POS_W'(want.busy));
			check_field("move_done", smbp_pkg::POS_W'(move_done),
				smbp_pkg::POS_W'(want.done));
			check_field("rejected", smbp_pkg::POS_W'(rejected),
				smbp_pkg::POS_W'(want.rej));
			check_field("position", position, want.pos);
		end
		result_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pins_t res;
		if (!arst_n) begin
			cfg.microsteps_per_mm = smbp_pkg::RST_MICROSTEPS_PER_MM;
			cfg.backlash_to_inward = smbp_pkg::RST_BACKLASH_INWARD;
			cfg.backlash_to_outward = smbp_pkg::RST_BACKLASH_OUTWARD;
			cfg.half_period_ticks = smbp_pkg::RST_HALF_PERIOD;
			steps_left = '0;
			phase_ticks = '0;
			last_dir = 1'b1;
			step_pin = 1'b0;
			dir_pin = 1'b0;
			drv_off_pin = 1'b1;
			microstep_pos = '0;
			expected_pins_q.delete();
			fail_count = 0;
			pending_count = 0;
			result_count = 0;
			done_count = 0;
			reject_count = 0;
			motor_busy = 1'b0;
		end else begin
			// track register writes
			if (cfg_we) begin
				case (cfg_index)
				smbp_pkg::REG_MICROSTEPS_PER_MM: cfg.microsteps_per_mm = cfg_data;
				smbp_pkg::REG_BACKLASH_INWARD:   cfg.backlash_to_inward = cfg_data;
				smbp_pkg::REG_BACKLASH_OUTWARD:  cfg.backlash_to_outward = cfg_data;
				smbp_pkg::REG_HALF_PERIOD:       cfg.half_period_ticks = cfg_data;
				default:                         ;
				endcase
			end
			if (out_valid && !out_stall)
				compare_result();
			// predict each accepted request
			if (in_valid && !in_stall) begin
				advance_motor(kind, direction, distance_microns, pin_select, res);
				expected_pins_q.push_back(res);
				if (res.done)
					done_count++;
				if (res.rej)
					reject_count++;
			end
			pending_count = expected_pins_q.size();
			motor_busy = (steps_left != '0);
		end
	end

endmodule

/* tb/tb_stepper_move_backlash_pulser.sv */
`timescale 1ns / 1ps
// Testbench top for the stepper move pulser: stimulus, idling and verdict.
module tb_stepper_move_backlash_pulser;

	localparam int         HALF_CLK    = 4;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] PIN_NONE    = 2'd3;
	localparam logic       DIR_INWARD  = 1'b0;
	localparam logic       DIR_OUTWARD = 1'b1;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_we;
	logic [smbp_pkg::REG_IDX_W-1:0]      cfg_index;
	logic [smbp_pkg::CFG_W-1:0]          cfg_data;
	logic                                in_valid;
	logic                                in_stall;
	logic [1:0]                          kind;
	logic                                direction;
	logic [smbp_pkg::DIST_W-1:0]         distance_microns;
	logic [1:0]                          pin_select;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic                                step_level;
	logic                                dir_level;
	logic                                enable_level;
	logic                                busy_res;
	logic                                move_done;
	logic                                rejected;
	logic signed [smbp_pkg::POS_W-1:0]   position;

	int   fail_count;
	int   pending_count;
	int   result_count;
	int   done_count;
	int   reject_count;
	logic motor_busy;

	int   request_count;
	int   send_idle_pct;
	int   stall_pct;
	logic calm = 1'b0;

	stepper_move_backlash_pulser uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .direction(direction), .distance_microns(distance_microns),
		.pin_select(pin_select),
		.out_valid(out_valid), .out_stall(out_stall),
		.step_level(step_level), .dir_level(dir_level), .enable_level(enable_level),
		.busy_res(busy_res), .move_done(move_done), .rejected(rejected),
		.position(position)
	);

	smbp_checker pulse_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .direction(direction), .distance_microns(distance_microns),
		.pin_select(pin_select),
		.out_valid(out_valid), .out_stall(out_stall),
		.step_level(step_level), .dir_level(dir_level), .enable_level(enable_level),
		.busy_res(busy_res), .move_done(move_done), .rejected(rejected),
		.position(position),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count), .done_count(done_count),
		.reject_count(reject_count), .motor_busy(motor_busy)
	);

	always begin
		clk = 1'b0;
		#HALF_CLK;
		clk = 1'b1;
		#HALF_CLK;
	end

	// Receiver stalls; calm stretches switch all idling off for a while
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0)
			calm <= !calm;
		out_stall <= (!calm && stall_pct != 0) ? ($urandom_range(0, 99) < stall_pct) : 1'b0;
	end

	// Present one request and hold it until accepted; starts and ends at a falling edge
	task automatic send_request(input logic [1:0] k, input logic d,
			input logic [smbp_pkg::DIST_W-1:0] microns, input logic [1:0] pin);
		while (!calm && send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		direction <= d;
		distance_microns <= microns;
		pin_select <= pin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		request_count++;
	endtask

	// Stray request: a move (turned away) while busy or a tick while idle, a toggle or an unused kind
	task automatic side_request(input logic busy_now);
		logic [1:0] k;
		case ($urandom_range(0, 2))
		0:       k = busy_now ? smbp_pkg::KIND_MOVE : smbp_pkg::KIND_TICK;
		1:       k = smbp_pkg::KIND_TOGGLE;
		default: k = KIND_UNUSED;
		endcase
		send_request(k, 1'($urandom_range(0, 1)), 16'($urandom), 2'($urandom_range(0, 3)));
	endtask

	// Tick until the move finishes, with stray requests mixed in when noisy
	task automatic tick_until_idle(input logic noisy);
		while (motor_busy) begin
			if (noisy && $urandom_range(0, 7) == 0)
				side_request(1'b1);
			else
				send_request(smbp_pkg::KIND_TICK, 1'($urandom_range(0, 1)), 16'($urandom),
					2'($urandom_range(0, 3)));
		end
	endtask

	task automatic run_move(input logic d, input logic [smbp_pkg::DIST_W-1:0] microns,
			input logic noisy);
		send_request(smbp_pkg::KIND_MOVE, d, microns, 2'($urandom_range(0, 3)));
		tick_until_idle(noisy);
	endtask

	// Lower valid and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
	endtask

	task automatic set_config(input logic [smbp_pkg::CFG_W-1:0] rate, bl_in, bl_out, half);
		cfg_we <= 1'b1;
		cfg_index <= smbp_pkg::REG_MICROSTEPS_PER_MM;
		cfg_data <= rate;
		@(negedge clk);
		cfg_index <= smbp_pkg::REG_BACKLASH_INWARD;
		cfg_data <= bl_in;
		@(negedge clk);
		cfg_index <= smbp_pkg::REG_BACKLASH_OUTWARD;
		cfg_data <= bl_out;
		@(negedge clk);
		cfg_index <= smbp_pkg::REG_HALF_PERIOD;
		cfg_data <= half;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One setting: idle-time noise, then a move run to completion, repeated
	task automatic run_phase(input logic [smbp_pkg::CFG_W-1:0] rate, bl_in, bl_out, half,
			input int max_dist, input int goal);
		int start;
		drain();
		set_config(rate, bl_in, bl_out, half);
		start = request_count;
		while (request_count - start < goal) begin
			repeat ($urandom_range(0, 2))
				side_request(1'b0);
			run_move(1'($urandom_range(0, 1)), 16'($urandom_range(0, max_dist)), 1'b1);
		end
	endtask

	initial begin
		#1_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		kind <= smbp_pkg::KIND_TICK;
		direction <= DIR_INWARD;
		distance_microns <= '0;
		pin_select <= smbp_pkg::PIN_DIR;
		send_idle_pct = 0;
		stall_pct = 0;
		request_count = 0;
		repeat (4)
			@(negedge clk);
		arst_n = 1'b1;

		// Directed: idle requests and toggles at the reset settings
		send_request(smbp_pkg::KIND_TICK, DIR_INWARD, '0, smbp_pkg::PIN_DIR);
		send_request(KIND_UNUSED, DIR_OUTWARD, '1, PIN_NONE);
		send_request(smbp_pkg::KIND_TOGGLE, DIR_INWARD, '0, smbp_pkg::PIN_DIR);
		send_request(smbp_pkg::KIND_TOGGLE, DIR_INWARD, '0, smbp_pkg::PIN_STEP);
		send_request(smbp_pkg::KIND_TOGGLE, DIR_INWARD, '0, smbp_pkg::PIN_ENABLE);
		send_request(smbp_pkg::KIND_TOGGLE, DIR_INWARD, '0, PIN_NONE);
		send_request(smbp_pkg::KIND_TOGGLE, DIR_INWARD, '0, smbp_pkg::PIN_DIR);
		send_request(smbp_pkg::KIND_TOGGLE, DIR_INWARD, '0, smbp_pkg::PIN_STEP);
		send_request(smbp_pkg::KIND_TOGGLE, DIR_INWARD, '0, smbp_pkg::PIN_ENABLE);
		// one microstep at the reset rate, moves and toggles while busy get turned away
		send_request(smbp_pkg::KIND_MOVE, DIR_OUTWARD, 16'd3, smbp_pkg::PIN_DIR);
		send_request(smbp_pkg::KIND_TOGGLE, DIR_INWARD, '0, smbp_pkg::PIN_ENABLE);
		send_request(smbp_pkg::KIND_MOVE, DIR_INWARD, '1, smbp_pkg::PIN_DIR);
		send_request(KIND_UNUSED, DIR_INWARD, '0, smbp_pkg::PIN_STEP);
		tick_until_idle(1'b0);
		// zero rate: zero-length moves and backlash on each reversal, half period zero
		drain();
		set_config(16'd0, 16'd2, 16'd3, 16'd0);
		run_move(DIR_OUTWARD, '1, 1'b0);
		run_move(DIR_INWARD, '1, 1'b0);
		run_move(DIR_INWARD, '0, 1'b0);
		run_move(DIR_OUTWARD, '0, 1'b0);

		// Sender idles often less than the receiver stalls
		send_idle_pct = 24;
		stall_pct = 63;
		run_phase(16'd0, 16'd3, 16'd0, 16'd2, 65535, 150);
		run_phase(16'd1000, 16'd2, 16'd1, 16'd0, 6, 150);

		// And the other way round
		send_idle_pct = 63;
		stall_pct = 24;
		run_phase(16'd1, 16'd0, 16'd4, 16'd1, 65535, 150);
		run_phase(16'hFFFF, 16'd1, 16'd1, 16'd0, 1, 150);

		// No idling: a random setting, then a long backlash and a long half period
		send_idle_pct = 0;
		stall_pct = 0;
		run_phase(16'($urandom_range(0, 1500)), 16'($urandom_range(0, 4)),
			16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)), 6, 200);
		drain();
		set_config(16'd0, 16'd60, 16'd0, 16'd0);
		run_move(DIR_OUTWARD, '0, 1'b0);
		run_move(DIR_INWARD, '0, 1'b0);
		drain();
		set_config(16'd1000, 16'd0, 16'hFFFF, 16'd40);
		run_move(DIR_INWARD, 16'd1, 1'b0);

		drain();
		repeat (8)
			@(negedge clk);
		$display("covered %0d requests over nine register settings, two idling mixes and none",
			request_count);
		$display("%0d results compared, %0d moves finished, %0d requests turned away",
			result_count, done_count, reject_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
